// ===== rtl/tcpr_pkg.sv =====
// tcpr_pkg: shared constants, types and the colour palette of the text cell renderer
// no dependencies; used by every module of the block but tcpr_checker by scoped names
`default_nettype none

package tcpr_pkg;

    localparam int MAX_SCALE    = 4;
    localparam int LEAD_ROWS    = 2;
    localparam int FIRST_CODE   = 32;
    localparam int LAST_CODE    = 126;
    localparam int FONT_W       = 8;
    localparam int FONT_H       = 8;
    localparam int MISSING_SLOT = LAST_CODE - FIRST_CODE + 1;
    localparam int SLOT_COUNT   = MISSING_SLOT + 1;

    localparam int SLOT_W  = 7;
    localparam int GROW_W  = 3;
    localparam int ADDR_W  = SLOT_W + GROW_W;
    localparam int MEM_DEPTH = SLOT_COUNT * FONT_H;
    localparam int SCALE_W = 3;
    localparam int COORD_W = 13;

    // request codes
    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // attribute bit positions
    localparam int ATTR_BOLD    = 0;
    localparam int ATTR_UNDER   = 1;
    localparam int ATTR_REVERSE = 2;

    // one decoded draw word, handed from the front end to the pixel emitter
    typedef struct packed {
        logic                 use_glyph;
        logic                 under;
        logic [3:0]           ink_idx;
        logic [3:0]           back_idx;
        logic [SCALE_W-1:0]   scale;
        logic [COORD_W-1:0]   x0;
        logic [COORD_W-1:0]   y;
    } t_draw;

    function automatic logic [31:0] palette(input logic [3:0] idx);
        logic [31:0] c;
        case (idx)
            4'd0:    c = 32'hff000000;
            4'd1:    c = 32'hffcd0000;
            4'd2:    c = 32'hff00cd00;
            4'd3:    c = 32'hffcdcd00;
            4'd4:    c = 32'hff0000ee;
            4'd5:    c = 32'hffcd00cd;
            4'd6:    c = 32'hff00cdcd;
            4'd7:    c = 32'hffe5e5e5;
            4'd8:    c = 32'hff7f7f7f;
            4'd9:    c = 32'hffff0000;
            4'd10:   c = 32'hff00ff00;
            4'd11:   c = 32'hffffff00;
            4'd12:   c = 32'hff5c5cff;
            4'd13:   c = 32'hffff00ff;
            4'd14:   c = 32'hff00ffff;
            default: c = 32'hffffffff;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tcpr_glyph_mem.sv =====
// tcpr_glyph_mem: glyph row store, one write port and one registered read port
// depends on tcpr_pkg
`default_nettype none

module tcpr_glyph_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [tcpr_pkg::ADDR_W-1:0] i_wr_addr,
    input  wire logic [7:0]                 i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [tcpr_pkg::ADDR_W-1:0] i_rd_addr,
    output logic      [7:0]                 o_rd_data
);

    logic [7:0] r_mem [tcpr_pkg::MEM_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/tcpr_emit.sv =====
// tcpr_emit: steps through one decoded glyph row and registers one pixel word per cycle while the output is not stalled
// depends on tcpr_pkg (t_draw, palette)
`default_nettype none

module tcpr_emit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_draw_valid,
    input  wire tcpr_pkg::t_draw              i_draw,
    input  wire logic [7:0]                   i_glyph_bits,
    output logic                              o_take,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [31:0]                       o_argb,
    output logic [tcpr_pkg::COORD_W-1:0]      o_pixel_x,
    output logic [tcpr_pkg::COORD_W-1:0]      o_pixel_y,
    output logic                              o_last
);

    logic                            r_e_valid;
    logic [7:0]                      r_bits;
    logic                            r_under;
    logic [3:0]                      r_ink;
    logic [3:0]                      r_back;
    logic [tcpr_pkg::SCALE_W-1:0]    r_scale;
    logic [tcpr_pkg::SCALE_W-1:0]    r_sub;
    logic [2:0]                      r_gx;
    logic [tcpr_pkg::COORD_W-1:0]    r_px;
    logic [tcpr_pkg::COORD_W-1:0]    r_py;

    logic                            r_o_valid;
    logic [31:0]                     r_o_argb;
    logic [tcpr_pkg::COORD_W-1:0]    r_o_px;
    logic [tcpr_pkg::COORD_W-1:0]    r_o_py;
    logic                            r_o_last;

    logic advance;
    logic sub_end;
    logic e_last;
    logic e_done;
    logic take;
    logic on;

    assign advance = r_e_valid && (!r_o_valid || i_ready);
    assign sub_end = (r_sub == r_scale - tcpr_pkg::SCALE_W'(1));
    assign e_last  = sub_end && (r_gx == 3'(tcpr_pkg::FONT_W - 1));
    assign e_done  = advance && e_last;
    assign take    = i_draw_valid && (!r_e_valid || e_done);
    assign on      = r_under || r_bits[r_gx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (take) begin
            r_e_valid <= 1'b1;
        end else if (e_done) begin
            r_e_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_bits  <= i_draw.use_glyph ? i_glyph_bits : 8'd0;
            r_under <= i_draw.under;
            r_ink   <= i_draw.ink_idx;
            r_back  <= i_draw.back_idx;
            r_scale <= i_draw.scale;
            r_sub   <= '0;
            r_gx    <= '0;
            r_px    <= i_draw.x0;
            r_py    <= i_draw.y;
        end else if (advance) begin
            if (sub_end) begin
                r_sub <= '0;
                r_gx  <= r_gx + 3'd1;
            end else begin
                r_sub <= r_sub + tcpr_pkg::SCALE_W'(1);
            end
            r_px <= r_px + tcpr_pkg::COORD_W'(1);
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_argb <= tcpr_pkg::palette(on ? r_ink : r_back);
            r_o_px   <= r_px;
            r_o_py   <= r_py;
            r_o_last <= e_last;
        end
    end

    assign o_take    = take;
    assign o_valid   = r_o_valid;
    assign o_argb    = r_o_argb;
    assign o_pixel_x = r_o_px;
    assign o_pixel_y = r_o_py;
    assign o_last    = r_o_last;

endmodule

`default_nettype wire

// ===== rtl/text_cell_pixel_row_renderer.sv =====
// text_cell_pixel_row_renderer: top level of the 8x8 text-mode character generator
// depends on tcpr_pkg, tcpr_glyph_mem and tcpr_emit
//
//  channel   direction  handshake            contents
//  input     in         i_valid / o_ready    draw or glyph load word
//  output    out        o_valid / i_ready    one argb pixel with its position
//  config    in         i_cfg_wr_en          scale register, no back-pressure
//
// a draw word gives 8*scale pixel words, one per cycle while the output is not stalled;
// a glyph load gives no pixel words
// the glyph memory is read when a draw word is accepted; its registered data is used when the emitter takes the word
// synchronous active-low reset clears the handshake state and sets scale to 1;
// the glyph memory is not cleared
// a stalled output holds the emitter; one decoded draw word waits in a holding stage
`default_nettype none

module text_cell_pixel_row_renderer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [2:0]                 i_cfg_wr_data,
    // input word
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_req_type,
    input  wire logic [20:0]                i_char_code,
    input  wire logic [3:0]                 i_fg_color,
    input  wire logic [3:0]                 i_bg_color,
    input  wire logic [2:0]                 i_attributes,
    input  wire logic                       i_cursor_here,
    input  wire logic [7:0]                 i_cell_col,
    input  wire logic [6:0]                 i_cell_row,
    input  wire logic [5:0]                 i_pixel_row,
    input  wire logic [6:0]                 i_glyph_slot,
    input  wire logic [2:0]                 i_glyph_row,
    input  wire logic [7:0]                 i_glyph_bits,
    // output word
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [31:0]                     o_argb,
    output logic [12:0]                     o_pixel_x,
    output logic [12:0]                     o_pixel_y,
    output logic                            o_last
);

    logic [tcpr_pkg::SCALE_W-1:0] r_scale;

    logic                         r_s1_valid;
    tcpr_pkg::t_draw              r_s1;
    tcpr_pkg::t_draw              n_s1;

    logic                         accept;
    logic                         draw_acc;
    logic                         load_en;
    logic                         take;
    logic [7:0]                   rd_data;

    logic [tcpr_pkg::SCALE_W-1:0] eff_scale;
    logic [5:0]                   cell_w;
    logic [5:0]                   cell_h;
    logic [11:0]                  third;
    logic [5:0]                   gy;
    logic                         in_cell;
    logic                         in_font;
    logic [tcpr_pkg::SLOT_W-1:0]  slot;
    logic [tcpr_pkg::ADDR_W-1:0]  rd_addr;
    logic                         swap;
    logic [3:0]                   fg;
    logic [3:0]                   bg;
    logic [12:0]                  row_base;

    // scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= tcpr_pkg::SCALE_W'(1);
        end else if (i_cfg_wr_en) begin
            r_scale <= i_cfg_wr_data;
        end
    end

    // zero acts as one, anything above the maximum is clamped
    always_comb begin
        if (r_scale == '0) begin
            eff_scale = tcpr_pkg::SCALE_W'(1);
        end else if (r_scale > tcpr_pkg::SCALE_W'(tcpr_pkg::MAX_SCALE)) begin
            eff_scale = tcpr_pkg::SCALE_W'(tcpr_pkg::MAX_SCALE);
        end else begin
            eff_scale = r_scale;
        end
    end

    assign cell_w = 6'(eff_scale) * 6'(tcpr_pkg::FONT_W);
    assign cell_h = 6'(eff_scale) * 6'(tcpr_pkg::FONT_H + tcpr_pkg::LEAD_ROWS);

    // glyph row = pixel row / scale; divide by three through 43/128
    assign third = 12'(i_pixel_row) * 12'd43;
    always_comb begin
        case (eff_scale)
            3'd2:    gy = i_pixel_row >> 1;
            3'd3:    gy = third[11:7] == 5'd0 ? 6'd0 : {1'b0, third[11:7]};
            3'd4:    gy = i_pixel_row >> 2;
            default: gy = i_pixel_row;
        endcase
    end

    assign in_cell = i_pixel_row < cell_h;
    assign in_font = (i_char_code >= 21'(tcpr_pkg::FIRST_CODE))
                  && (i_char_code <= 21'(tcpr_pkg::LAST_CODE));
    assign slot    = in_font ? tcpr_pkg::SLOT_W'(i_char_code - 21'(tcpr_pkg::FIRST_CODE))
                             : tcpr_pkg::SLOT_W'(tcpr_pkg::MISSING_SLOT);
    assign rd_addr = {slot, gy[2:0]};

    // cursor is a reverse of what lies under it; bold brightens the ink
    assign swap = i_attributes[tcpr_pkg::ATTR_REVERSE] ^ i_cursor_here;
    assign fg   = swap ? i_bg_color : i_fg_color;
    assign bg   = swap ? i_fg_color : i_bg_color;

    assign row_base = 13'(i_cell_row) * 13'(cell_h);

    always_comb begin
        n_s1.use_glyph = in_cell && (i_char_code != 21'd0) && (gy < 6'(tcpr_pkg::FONT_H));
        n_s1.under     = in_cell && i_attributes[tcpr_pkg::ATTR_UNDER]
                      && (gy == 6'(tcpr_pkg::FONT_H - 1));
        n_s1.ink_idx   = {fg[3] | i_attributes[tcpr_pkg::ATTR_BOLD], fg[2:0]};
        n_s1.back_idx  = bg;
        n_s1.scale     = eff_scale;
        n_s1.x0        = 13'(i_cell_col) * 13'(cell_w);
        n_s1.y         = row_base + 13'(i_pixel_row);
    end

    assign o_ready  = !r_s1_valid || take;
    assign accept   = i_valid && o_ready;
    assign draw_acc = accept && (i_req_type == tcpr_pkg::REQ_DRAW);
    // loads past the missing-glyph slot are dropped
    assign load_en  = accept && (i_req_type == tcpr_pkg::REQ_LOAD)
                   && (i_glyph_slot < 7'(tcpr_pkg::SLOT_COUNT));

    // holding stage: glyph read data arrives while the word sits here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (draw_acc) begin
            r_s1_valid <= 1'b1;
        end else if (take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (draw_acc) begin
            r_s1 <= n_s1;
        end
    end

    // read happens only on a draw accept, so the read data holds while the word waits;
    // a load written at an earlier edge is seen by every later read
    tcpr_glyph_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (load_en),
        .i_wr_addr ({i_glyph_slot, i_glyph_row}),
        .i_wr_data (i_glyph_bits),
        .i_rd_en   (draw_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tcpr_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_draw_valid (r_s1_valid),
        .i_draw       (r_s1),
        .i_glyph_bits (rd_data),
        .o_take       (take),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_argb       (o_argb),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ===== rtl/tcpr_checker.sv =====
// tcpr_checker: port-level assertions for the text cell renderer, bound to the top level
// depends on text_cell_pixel_row_renderer port list only
`default_nettype none

module tcpr_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_valid,
    input  wire logic        i_ready,
    input  wire logic [31:0] o_argb,
    input  wire logic [12:0] o_pixel_x,
    input  wire logic [12:0] o_pixel_y,
    input  wire logic        o_last
);

    // nothing on the output the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid straight after reset");

    // a row carries on without a gap once its pixels flow
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=>
            o_valid && (o_pixel_x == $past(o_pixel_x) + 13'd1)
                    && (o_pixel_y == $past(o_pixel_y)))
        else $error("pixel row not contiguous");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output valid dropped while stalled");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=>
            $stable(o_argb) && $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_last))
        else $error("output word changed while stalled");

endmodule

bind text_cell_pixel_row_renderer tcpr_checker u_tcpr_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_argb    (o_argb),
    .o_pixel_x (o_pixel_x),
    .o_pixel_y (o_pixel_y),
    .o_last    (o_last)
);

`default_nettype wire
